@@ hdl/itla_pkg.sv @@
// Shared constants and the arctangent table for the look-angle pipeline.
// Used by every module of the block.
`default_nettype none
package itla_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int DW = 64;
  localparam int AW = 34;
  localparam logic [29:0] GAIN_INV_Q30 = 30'd652032874;
  localparam logic signed [AW-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [AW-1:0] HALF_TURN = 34'sd2147483648;

  function automatic logic signed [AW-1:0] atan_ang(input int idx);
    logic [31:0] a;
    unique case (idx)
      0: a = 32'h20000000;  1: a = 32'h12E4051E;  2: a = 32'h09FB385B;
      3: a = 32'h051111D4;  4: a = 32'h028B0D43;  5: a = 32'h0145D7E1;
      6: a = 32'h00A2F61E;  7: a = 32'h00517C55;  8: a = 32'h0028BE53;
      9: a = 32'h00145F2F; 10: a = 32'h000A2F98; 11: a = 32'h000517CC;
      12: a = 32'h00028BE6; 13: a = 32'h000145F3; 14: a = 32'h0000A2FA;
      15: a = 32'h0000517D; 16: a = 32'h000028BE; 17: a = 32'h0000145F;
      18: a = 32'h00000A30; 19: a = 32'h00000518; 20: a = 32'h0000028C;
      21: a = 32'h00000146; 22: a = 32'h000000A3; 23: a = 32'h00000051;
      24: a = 32'h00000029; 25: a = 32'h00000014; 26: a = 32'h0000000A;
      27: a = 32'h00000005; 28: a = 32'h00000003; 29: a = 32'h00000001;
      30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return $signed({2'b00, a});
  endfunction

endpackage
`default_nettype wire

@@ hdl/itla_gain.sv @@
// CORDIC gain removal: multiply by 652032874 / 2^30, round half away from zero.
// Three register stages, advanced by the shared clock enable. Uses itla_pkg.
`default_nettype none
module itla_gain (
  input  wire logic clk,
  input  wire logic ce,
  input  wire logic signed [itla_pkg::DW-1:0] d,
  output logic signed [itla_pkg::DW-1:0] q
);
  import itla_pkg::*;

  logic [DW-1:0] mag;
  logic          neg1;
  logic [DW-1:0] p_hi;
  logic [59:0]   p_lo;
  logic          neg2;
  logic [DW-1:0] sum;

  assign sum = p_hi + DW'((p_lo + 60'd536870912) >> 30);

  always_ff @(posedge clk) begin
    if (ce) begin
      mag  <= d[DW-1] ? DW'(-d) : DW'(d);
      neg1 <= d[DW-1];
      p_hi <= DW'({30'd0, mag[DW-1:30]} * {34'd0, GAIN_INV_Q30});
      p_lo <= {30'd0, mag[29:0]} * {30'd0, GAIN_INV_Q30};
      neg2 <= neg1;
      q    <= neg2 ? $signed(-sum) : $signed(sum);
    end
  end
endmodule
`default_nettype wire

@@ hdl/itla_rot.sv @@
// Rotation-mode CORDIC: quadrant fold, one stage per iteration, gain removal.
// Uses itla_pkg and itla_gain.
`default_nettype none
module itla_rot #(
  parameter int STAGES = itla_pkg::CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic ce,
  input  wire logic in_valid,
  input  wire logic signed [itla_pkg::DW-1:0] in_x,
  input  wire logic signed [itla_pkg::DW-1:0] in_y,
  input  wire logic [31:0] in_ang,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic out_valid,
  output logic signed [itla_pkg::DW-1:0] out_x,
  output logic signed [itla_pkg::DW-1:0] out_y,
  output logic [SIDE_W-1:0] out_side
);
  import itla_pkg::*;

  localparam int LAT = STAGES + 4;

  logic signed [DW-1:0] x [STAGES+1];
  logic signed [DW-1:0] y [STAGES+1];
  logic signed [AW-1:0] z [STAGES+1];
  logic                 vld [LAT];
  logic [SIDE_W-1:0]    side [LAT];
  logic signed [AW-1:0] z_in;

  assign z_in = $signed({{2{in_ang[31]}}, in_ang});

  always_ff @(posedge clk) begin
    if (ce) begin
      if (z_in > QUARTER_TURN) begin
        x[0] <= -in_x; y[0] <= -in_y; z[0] <= z_in - HALF_TURN;
      end else if (z_in < -QUARTER_TURN) begin
        x[0] <= -in_x; y[0] <= -in_y; z[0] <= z_in + HALF_TURN;
      end else begin
        x[0] <= in_x; y[0] <= in_y; z[0] <= z_in;
      end
      side[0] <= in_side;
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (ce) begin
        if (!z[k][AW-1]) begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          z[k+1] <= z[k] - atan_ang(k);
        end else begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          z[k+1] <= z[k] + atan_ang(k);
        end
      end
    end
  end

  for (genvar j = 1; j < LAT; j++) begin : g_pipe
    always_ff @(posedge clk) begin
      if (ce) side[j] <= side[j-1];
    end
    always_ff @(posedge clk) begin
      if (rst) vld[j] <= 1'b0;
      else if (ce) vld[j] <= vld[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (ce) vld[0] <= in_valid;
  end

  itla_gain u_gx (.clk(clk), .ce(ce), .d(x[STAGES]), .q(out_x));
  itla_gain u_gy (.clk(clk), .ce(ce), .d(y[STAGES]), .q(out_y));

  assign out_valid = vld[LAT-1];
  assign out_side  = side[LAT-1];
endmodule
`default_nettype wire

@@ hdl/itla_vec.sv @@
// Vectoring-mode CORDIC: half-plane fold, one stage per iteration, gain removal.
// Gives atan2(y, x) in 2^32 counts per turn and the magnitude.
`default_nettype none
module itla_vec #(
  parameter int STAGES = itla_pkg::CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic ce,
  input  wire logic in_valid,
  input  wire logic signed [itla_pkg::DW-1:0] in_x,
  input  wire logic signed [itla_pkg::DW-1:0] in_y,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic out_valid,
  output logic [31:0] out_ang,
  output logic signed [itla_pkg::DW-1:0] out_mag,
  output logic [SIDE_W-1:0] out_side
);
  import itla_pkg::*;

  localparam int LAT = STAGES + 4;
  localparam int SW = SIDE_W + 2;

  logic signed [DW-1:0] x [STAGES+1];
  logic signed [DW-1:0] y [STAGES+1];
  logic signed [AW-1:0] z [STAGES+1];
  logic                 vld [LAT];
  logic [SW-1:0]        side [LAT];
  logic [31:0]          ang [3];
  logic                 zero_in;

  assign zero_in = (in_x == '0) && (in_y == '0);

  always_ff @(posedge clk) begin
    if (ce) begin
      if (in_x[DW-1]) begin
        x[0] <= -in_x; y[0] <= -in_y;
      end else begin
        x[0] <= in_x; y[0] <= in_y;
      end
      z[0] <= '0;
      side[0] <= {zero_in, in_x[DW-1], in_side};
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (ce) begin
        if (y[k][DW-1]) begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          z[k+1] <= z[k] - atan_ang(k);
        end else begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          z[k+1] <= z[k] + atan_ang(k);
        end
      end
    end
  end

  for (genvar j = 1; j < LAT; j++) begin : g_pipe
    always_ff @(posedge clk) begin
      if (ce) side[j] <= side[j-1];
    end
    always_ff @(posedge clk) begin
      if (rst) vld[j] <= 1'b0;
      else if (ce) vld[j] <= vld[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (ce) vld[0] <= in_valid;
  end

  // hold the angle beside the gain stages
  always_ff @(posedge clk) begin
    if (ce) begin
      if (side[STAGES][SW-1]) ang[0] <= '0;
      else ang[0] <= {side[STAGES][SW-2], 31'd0} + 32'(z[STAGES]);
      ang[1] <= ang[0];
      ang[2] <= ang[1];
    end
  end

  itla_gain u_gm (.clk(clk), .ce(ce), .d(x[STAGES]), .q(out_mag));

  assign out_valid = vld[LAT-1];
  assign out_side  = side[LAT-1][SIDE_W-1:0];
  assign out_ang   = ang[2];
endmodule
`default_nettype wire

@@ hdl/inertial_to_topocentric_look_angles.sv @@
// Throughput: one item per cycle; the whole pipeline advances on one enable that
// drops only while the output register holds a result not yet taken.
// Reset: synchronous, active high; clears valid bits and sets latitude and
// observer_z to zero. Depends on itla_pkg, itla_rot, itla_vec, itla_gain.
`default_nettype none
module inertial_to_topocentric_look_angles #(
  parameter int CORDIC_STAGES = itla_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // sidereal_angle, observer_x, observer_y, target_x, target_y, target_z
  input  wire logic [183:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // azimuth, elevation, slant_range, zero padding
  output logic [87:0]       m_tdata,
  // zero_range
  output logic              m_tuser,
  input  wire logic         wr_en,
  input  wire logic         wr_index,
  input  wire logic [31:0]  wr_data
);
  import itla_pkg::*;

  localparam logic REG_LATITUDE = 1'b0;
  localparam logic REG_OBS_Z    = 1'b1;

  logic [23:0] latitude;
  logic [31:0] observer_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      latitude   <= '0;
      observer_z <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LATITUDE: latitude   <= wr_data[23:0];
        REG_OBS_Z:    observer_z <= wr_data;
        default:      latitude   <= latitude;
      endcase
    end
  end

  logic ce;
  assign ce = !m_tvalid || m_tready;
  assign s_tready = ce;

  logic signed [32:0] ex, ey, ez;
  assign ex = $signed({s_tdata[119], s_tdata[119:88]}) - $signed({s_tdata[55], s_tdata[55:24]});
  assign ey = $signed({s_tdata[151], s_tdata[151:120]}) - $signed({s_tdata[87], s_tdata[87:56]});
  assign ez = $signed({s_tdata[183], s_tdata[183:152]}) - $signed({observer_z[31], observer_z});

  logic                 va;
  logic signed [DW-1:0] pxa, pya, hza;
  logic [31:0]          anga;
  logic                 zeroa;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (ce) va <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pxa   <= $signed({{15{ex[32]}}, ex, 16'd0});
      pya   <= $signed({{15{ey[32]}}, ey, 16'd0});
      hza   <= $signed({{15{ez[32]}}, ez, 16'd0});
      anga  <= 32'd0 - {s_tdata[23:0], 8'd0};
      zeroa <= (ex == '0) && (ey == '0) && (ez == '0);
    end
  end

  logic                 v1;
  logic signed [DW-1:0] px1, py1;
  logic [DW:0]          side1;

  itla_rot #(.STAGES(CORDIC_STAGES), .SIDE_W(DW + 1)) u_rot_sid (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(va),
    .in_x(pxa), .in_y(pya), .in_ang(anga), .in_side({zeroa, hza}),
    .out_valid(v1), .out_x(px1), .out_y(py1), .out_side(side1)
  );

  logic                 v2;
  logic signed [DW-1:0] hx2, hz2;
  logic [DW:0]          side2;
  logic [31:0]          lat_ang;

  assign lat_ang = 32'd0 - {latitude, 8'd0};

  itla_rot #(.STAGES(CORDIC_STAGES), .SIDE_W(DW + 1)) u_rot_lat (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v1),
    .in_x(px1), .in_y($signed(side1[DW-1:0])), .in_ang(lat_ang),
    .in_side({side1[DW], py1}),
    .out_valid(v2), .out_x(hx2), .out_y(hz2), .out_side(side2)
  );

  logic                 v3;
  logic [31:0]          az3;
  logic signed [DW-1:0] horiz3;
  logic [DW:0]          side3;

  itla_vec #(.STAGES(CORDIC_STAGES), .SIDE_W(DW + 1)) u_vec_az (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v2),
    .in_x(-hz2), .in_y(-$signed(side2[DW-1:0])), .in_side({side2[DW], hx2}),
    .out_valid(v3), .out_ang(az3), .out_mag(horiz3), .out_side(side3)
  );

  logic                 v4;
  logic [31:0]          el4;
  logic signed [DW-1:0] dist4;
  logic [32:0]          side4;

  itla_vec #(.STAGES(CORDIC_STAGES), .SIDE_W(33)) u_vec_el (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v3),
    .in_x(horiz3), .in_y($signed(side3[DW-1:0])), .in_side({side3[DW], az3}),
    .out_valid(v4), .out_ang(el4), .out_mag(dist4), .out_side(side4)
  );

  logic [DW-1:0] rng_full;
  logic [32:0]   rng;
  logic [31:0]   az_r, el_r;

  assign rng_full = (DW'(dist4) + DW'(32768)) >> 16;
  assign rng  = (rng_full[DW-1:33] != '0) ? '1 : rng_full[32:0];
  assign az_r = side4[31:0] + 32'd128;
  assign el_r = el4 + 32'd128;

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (ce) m_tvalid <= v4;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= {7'd0, rng, el_r[31:8], az_r[31:8]};
      m_tuser <= side4[32];
    end
  end
endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for inertial_to_topocentric_look_angles.
// Drives stream transfers under varied idling and compares each result against
// an in-bench CORDIC predictor; needs only the block's RTL and itla_pkg.
`default_nettype none
module tb;

  localparam int STAGES = 24;
  localparam int LATENCY = 4 * STAGES + 18;
  localparam bit [63:0] GAIN_Q30 = 64'd652032874;
  localparam longint HALF = 64'sd2147483648;
  localparam longint QUARTER = 64'sd1073741824;
  localparam bit [31:0] ATAN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};

  typedef enum logic {REG_LATITUDE = 1'b0, REG_OBSERVER_Z = 1'b1} reg_index_e;

  typedef struct {
    bit [23:0] sid;
    int ox, oy, tx, ty, tz;
  } sample_t;

  typedef struct {
    bit [23:0] az, el;
    bit [32:0] rng;
    bit zr;
  } look_t;

  class look_angle_board;
    bit [23:0] lat;
    int obs_z;
    look_t pending[$];
    int errors;

    function longint gain_fix(longint v);
      bit [63:0] m, r;
      m = (v < 0) ? -v : v;
      r = (m >> 30) * GAIN_Q30 + (((m & 64'h3FFFFFFF) * GAIN_Q30 + 64'h20000000) >> 30);
      return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function void rotate(inout longint x, inout longint y, input bit [31:0] ang);
      longint z, nx, a;
      z = ang[31] ? longint'(ang) - 64'sd4294967296 : longint'(ang);
      if (z > QUARTER) begin
        x = -x; y = -y; z -= HALF;
      end else if (z < -QUARTER) begin
        x = -x; y = -y; z += HALF;
      end
      for (int i = 0; i < STAGES; i++) begin
        a = longint'(ATAN[i]);
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= a;
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z += a;
        end
        x = nx;
      end
      x = gain_fix(x);
      y = gain_fix(y);
    endfunction

    function bit [31:0] vector_angle(longint x, longint y, output longint mag);
      bit [31:0] base;
      longint z, nx, a;
      base = 0;
      z = 0;
      if (x == 0 && y == 0) begin
        mag = 0;
        return 0;
      end
      if (x < 0) begin
        x = -x; y = -y; base = 32'h80000000;
      end
      for (int i = 0; i < STAGES; i++) begin
        a = longint'(ATAN[i]);
        if (y < 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= a;
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z += a;
        end
        x = nx;
      end
      mag = gain_fix(x);
      return base + z[31:0];
    endfunction

    function look_t predict(sample_t s);
      look_t res;
      longint ex, ey, ez, px, py, hx, hz, horiz, slant;
      bit [31:0] az, el, t;
      bit [63:0] r;
      ex = longint'(s.tx) - longint'(s.ox);
      ey = longint'(s.ty) - longint'(s.oy);
      ez = longint'(s.tz) - longint'(obs_z);
      res = '{az: 0, el: 0, rng: 0, zr: 1'b1};
      if (ex == 0 && ey == 0 && ez == 0) return res;
      px = ex <<< 16;
      py = ey <<< 16;
      hz = ez <<< 16;
      rotate(px, py, 32'd0 - {s.sid, 8'd0});
      hx = px;
      rotate(hx, hz, 32'd0 - {lat, 8'd0});
      az = vector_angle(-hz, -py, horiz);
      el = vector_angle(horiz, hx, slant);
      t = az + 32'd128;
      res.az = t[31:8];
      t = el + 32'd128;
      res.el = t[31:8];
      r = (64'(slant) + 64'h8000) >> 16;
      res.rng = (r > 64'h1FFFFFFFF) ? 33'h1FFFFFFFF : r[32:0];
      res.zr = 1'b0;
      return res;
    endfunction

    function void note_input(sample_t s);
      pending.push_back(predict(s));
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check(look_t got);
      look_t want;
      if (pending.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      want = pending.pop_front();
      if (got.az != want.az) report($sformatf("azimuth %h, want %h", got.az, want.az));
      if (got.el != want.el) report($sformatf("elevation %h, want %h", got.el, want.el));
      if (got.rng != want.rng) report($sformatf("range %h, want %h", got.rng, want.rng));
      if (got.zr != want.zr) report($sformatf("zero_range %b, want %b", got.zr, want.zr));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [183:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [87:0] m_tdata;
  logic m_tuser;
  logic wr_en = 0;
  logic wr_index = 0;
  logic [31:0] wr_data = '0;

  look_angle_board board = new();
  int sender_idle = 0;
  int recv_stall = 0;
  int hold_off = 0;

  inertial_to_topocentric_look_angles dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        board.check('{az: m_tdata[23:0], el: m_tdata[47:24], rng: m_tdata[80:48],
                      zr: m_tuser});
      if (hold_off > 0) begin
        m_tready <= 1'b0;
        hold_off <= hold_off - 1;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task send(sample_t s);
    while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {s.tz, s.ty, s.tx, s.oy, s.ox, s.sid};
    do @(posedge clk); while (!s_tready);
    board.note_input(s);
  endtask

  task drain;
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 16) @(posedge clk);
  endtask

  task write_reg(reg_index_e idx, logic [31:0] value);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_LATITUDE) board.lat = value[23:0];
    else board.obs_z = value;
  endtask

  function sample_t random_sample();
    sample_t s;
    int kind;
    kind = $urandom_range(9);
    s.sid = $urandom;
    s.ox = $urandom;
    s.oy = $urandom;
    s.tx = $urandom;
    s.ty = $urandom;
    s.tz = $urandom;
    if (kind inside {[5:6]}) begin
      s.tx = s.ox + $urandom_range(2000) - 1000;
      s.ty = s.oy + $urandom_range(2000) - 1000;
      s.tz = board.obs_z + $urandom_range(2000) - 1000;
    end else if (kind == 7) begin
      s.tx = s.ox;
      s.ty = s.oy;
      s.tz = board.obs_z;
    end else if (kind == 8) begin
      s.tx = s.ox + $urandom_range(1 << 20);
      s.ty = s.oy;
      s.tz = ($urandom_range(1)) ? board.obs_z : s.tz;
    end else if (kind == 9) begin
      s.ox = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      s.tx = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      s.tz = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
    end
    return s;
  endfunction

  initial begin
    sample_t s;
    int lat_set [6] = '{0, 4194304, -4194304, 1398101, -2796202, 0};
    int oz_set [6] = '{0, 32'h7FFFFFFF, 32'h80000000, 6371000, -6371000, 0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send('{sid: 0, ox: 0, oy: 0, tx: 0, ty: 0, tz: 0});
    send('{sid: 24'h123456, ox: 7, oy: -9, tx: 7, ty: -9, tz: 0});
    send('{sid: 0, ox: 0, oy: 0, tx: 1000, ty: 0, tz: 0});
    send('{sid: 0, ox: 0, oy: 0, tx: 0, ty: 0, tz: 1000});
    send('{sid: 0, ox: 0, oy: 0, tx: 0, ty: 0, tz: -1000});
    send('{sid: 0, ox: 0, oy: 0, tx: 0, ty: 1000, tz: 0});
    send('{sid: 24'hFFFFFF, ox: 0, oy: 0, tx: 0, ty: -1000, tz: 0});
    send('{sid: 24'h400000, ox: 1, oy: 2, tx: 5000, ty: 300, tz: 40});
    send('{sid: 24'h800000, ox: 1, oy: 2, tx: 5000, ty: 300, tz: 40});
    send('{sid: 24'hC00000, ox: 1, oy: 2, tx: 5000, ty: 300, tz: 40});
    send('{sid: 24'h200000, ox: 32'h80000000, oy: 32'h80000000, tx: 32'h7FFFFFFF,
           ty: 32'h7FFFFFFF, tz: 32'h7FFFFFFF});
    send('{sid: 24'hFFFFFF, ox: 32'h7FFFFFFF, oy: 32'h7FFFFFFF, tx: 32'h80000000,
           ty: 32'h80000000, tz: 32'h80000000});
    send('{sid: 24'h600000, ox: -1, oy: -1, tx: 1, ty: 1, tz: -1});
    send('{sid: 24'h000001, ox: 0, oy: 0, tx: 1, ty: 0, tz: 0});
    send('{sid: 24'h7FFFFF, ox: 0, oy: 0, tx: 0, ty: 0, tz: 1});
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_LATITUDE, lat_set[ph]);
      write_reg(REG_OBSERVER_Z, oz_set[ph]);
      if (ph == 5) begin
        write_reg(REG_LATITUDE, $urandom_range(8388608) - 4194304);
        write_reg(REG_OBSERVER_Z, $urandom);
      end
      sender_idle = (ph % 4 == 1) ? 74 : (ph % 4 == 3) ? 28 : 0;
      recv_stall = (ph % 4 == 2) ? 74 : (ph % 4 == 3) ? 28 : 0;
      if (ph == 4) hold_off <= 400;
      for (int k = 0; k < 132; k++) begin
        s = random_sample();
        send(s);
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
